// ===== sv/pid_step_angle_wrap_antiwindup_top_macros.svh =====
// assertion macros shared by the pid step block
`ifndef PID_STEP_ANGLE_WRAP_ANTIWINDUP_TOP_MACROS_SVH
`define PID_STEP_ANGLE_WRAP_ANTIWINDUP_TOP_MACROS_SVH

// property that must hold in the cycle after the antecedent
`define PIDSAW_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pidsaw: next-cycle check failed");

// property that must hold in the same cycle as the antecedent
`define PIDSAW_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pidsaw: same-cycle check failed");

`endif

// ===== sv/pidsaw_pkg.sv =====
// shared types, constants and arithmetic helpers of the pid step block
package pidsaw_pkg;

   // pi and two pi in q15.16
   localparam logic signed [31:0] PI_Q16     = 32'sd205887;
   localparam logic signed [31:0] TWO_PI_Q16 = 32'sd411775;

   // register reset values
   localparam logic signed [30:0] DRIVE_MIN_RESET = 31'sh4000_0000;
   localparam logic signed [30:0] DRIVE_MAX_RESET = 31'sh3FFF_FFFF;

   // integral saturation bounds
   localparam logic signed [48:0] INTEG_MAX = 49'sh0_0000_7FFF_FFFF;
   localparam logic signed [48:0] INTEG_MIN = -49'sh0_0000_8000_0000;

   // register indexes on the csr port
   typedef enum logic [2:0] {
      REG_KP_GAIN     = 3'd0,
      REG_KI_TIMES_DT = 3'd1,
      REG_KD_OVER_DT  = 3'd2,
      REG_DRIVE_MIN   = 3'd3,
      REG_DRIVE_MAX   = 3'd4,
      REG_ANGLE_MODE  = 3'd5
   } reg_index_type;

   // clamp status codes
   typedef enum logic [1:0] {
      LIMIT_NONE = 2'd0,
      LIMIT_HIGH = 2'd1,
      LIMIT_LOW  = 2'd2
   } limit_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic signed [31:0] kp_gain;
      logic signed [31:0] ki_times_dt;
      logic signed [31:0] kd_over_dt;
      logic signed [30:0] drive_min;
      logic signed [30:0] drive_max;
      logic               angle_mode;
   } cfg_type;

   // raw products handed from the front stage to the back stage
   typedef struct packed {
      logic signed [63:0] p_prod;
      logic signed [63:0] i_prod;
      logic signed [63:0] d_prod;
   } products_type;

   // wrap once by two pi when beyond plus or minus pi
   function automatic logic signed [31:0] wrap_angle(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (v > PI_Q16) begin
         r = v - TWO_PI_Q16;
      end else if (v < -PI_Q16) begin
         r = v + TWO_PI_Q16;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // q31.32 product to q31.16, round to nearest, ties up
   function automatic logic signed [47:0] round16(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = x + 64'sd32768;
      return y[63:16];
   endfunction

endpackage

// ===== sv/pidsaw_csr.sv =====
// apb-style register file holding gains, clamps and angle mode
module pidsaw_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output pidsaw_pkg::cfg_type   cfg
);

   pidsaw_pkg::cfg_type cfg_ff;
   pidsaw_pkg::cfg_type cfg_in;
   pidsaw_pkg::reg_index_type reg_sel;
   logic wr_en;

   assign reg_sel    = pidsaw_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            pidsaw_pkg::REG_KP_GAIN:     cfg_in.kp_gain     = csr_pwdata;
            pidsaw_pkg::REG_KI_TIMES_DT: cfg_in.ki_times_dt = csr_pwdata;
            pidsaw_pkg::REG_KD_OVER_DT:  cfg_in.kd_over_dt  = csr_pwdata;
            pidsaw_pkg::REG_DRIVE_MIN:   cfg_in.drive_min   = csr_pwdata[30:0];
            pidsaw_pkg::REG_DRIVE_MAX:   cfg_in.drive_max   = csr_pwdata[30:0];
            pidsaw_pkg::REG_ANGLE_MODE:  cfg_in.angle_mode  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // register state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain     <= '0;
         cfg_ff.ki_times_dt <= '0;
         cfg_ff.kd_over_dt  <= '0;
         cfg_ff.drive_min   <= pidsaw_pkg::DRIVE_MIN_RESET;
         cfg_ff.drive_max   <= pidsaw_pkg::DRIVE_MAX_RESET;
         cfg_ff.angle_mode  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         pidsaw_pkg::REG_KP_GAIN:     csr_prdata = cfg_ff.kp_gain;
         pidsaw_pkg::REG_KI_TIMES_DT: csr_prdata = cfg_ff.ki_times_dt;
         pidsaw_pkg::REG_KD_OVER_DT:  csr_prdata = cfg_ff.kd_over_dt;
         pidsaw_pkg::REG_DRIVE_MIN:   csr_prdata = 32'(cfg_ff.drive_min);
         pidsaw_pkg::REG_DRIVE_MAX:   csr_prdata = 32'(cfg_ff.drive_max);
         pidsaw_pkg::REG_ANGLE_MODE:  csr_prdata = {31'd0, cfg_ff.angle_mode};
         default:                     csr_prdata = '0;
      endcase
   end

endmodule

// ===== sv/pidsaw_front.sv =====
// input register, error and measurement difference, gain products
`include "pid_step_angle_wrap_antiwindup_top_macros.svh"
module pidsaw_front (
   input  logic                      clock,
   input  logic                      reset,
   input  pidsaw_pkg::cfg_type       cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [30:0]        req_target_value,
   input  logic signed [30:0]        req_measured_value,
   output logic                      prod_valid,
   input  logic                      prod_ready,
   output pidsaw_pkg::products_type  prod
);

   logic                     s1_valid_ff;
   logic signed [30:0]       s1_target_ff;
   logic signed [30:0]       s1_meas_ff;
   logic signed [30:0]       last_meas_ff;
   logic                     first_step_ff;
   logic                     s2_valid_ff;
   pidsaw_pkg::products_type prod_ff;
   pidsaw_pkg::products_type prod_in;

   logic s1_go;
   logic s2_free;
   logic req_take;
   logic signed [31:0] meas_ext;
   logic signed [31:0] err_raw;
   logic signed [31:0] err;
   logic signed [31:0] diff_raw;
   logic signed [31:0] diff;

   // stage handshake
   assign s2_free   = ~s2_valid_ff | prod_ready;
   assign s1_go     = s1_valid_ff & s2_free;
   assign req_ready = ~s1_valid_ff | s1_go;
   assign req_take  = req_valid & req_ready;

   // error and measurement difference, wrapped in angle mode; difference zero on the first step
   always_comb begin
      meas_ext = 32'(s1_meas_ff);
      err_raw  = 32'(s1_target_ff) - meas_ext;
      err      = cfg.angle_mode ? pidsaw_pkg::wrap_angle(err_raw) : err_raw;
      diff_raw = meas_ext - 32'(last_meas_ff);
      if (first_step_ff) begin
         diff = '0;
      end else if (cfg.angle_mode) begin
         diff = pidsaw_pkg::wrap_angle(diff_raw);
      end else begin
         diff = diff_raw;
      end
   end

   // three independent 32x32 products
   always_comb begin
      prod_in.p_prod = err * cfg.kp_gain;
      prod_in.i_prod = err * cfg.ki_times_dt;
      prod_in.d_prod = diff * cfg.kd_over_dt;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_take) begin
         s1_target_ff <= req_target_value;
         s1_meas_ff   <= req_measured_value;
      end
   end

   // previous measurement and first-step flag
   always_ff @(posedge clock) begin
      if (reset) begin
         first_step_ff <= 1'b1;
         last_meas_ff  <= '0;
      end else if (s1_go) begin
         first_step_ff <= 1'b0;
         last_meas_ff  <= s1_meas_ff;
      end
   end

   // product register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_go) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = s2_valid_ff;
   assign prod       = prod_ff;

   // checks
   `PIDSAW_ASSERT_NEXT(a_first_step_cleared, s1_go, !first_step_ff)
   `PIDSAW_ASSERT_NEXT(a_stalled_request_held, s1_valid_ff && !s1_go, s1_valid_ff)

endmodule

// ===== sv/pidsaw_back.sv =====
// integral update, sum, clamp with anti-windup and result register
`include "pid_step_angle_wrap_antiwindup_top_macros.svh"
module pidsaw_back (
   input  logic                      clock,
   input  logic                      reset,
   input  pidsaw_pkg::cfg_type       cfg,
   input  logic                      prod_valid,
   output logic                      prod_ready,
   input  pidsaw_pkg::products_type  prod,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [30:0]        rsp_drive_value,
   output logic [1:0]                rsp_limit_state
);

   logic signed [31:0]    integral_sum_ff;
   logic signed [31:0]    integral_sum_in;
   logic                  rsp_valid_ff;
   logic signed [30:0]    drive_ff;
   logic signed [30:0]    drive_in;
   pidsaw_pkg::limit_type limit_ff;
   pidsaw_pkg::limit_type limit_in;

   logic               out_free;
   logic               s2_go;
   logic signed [47:0] p_term;
   logic signed [47:0] d_term;
   logic signed [47:0] inc;
   logic signed [48:0] integ_wide;
   logic signed [31:0] integ;
   logic signed [49:0] sum;

   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign s2_go      = prod_valid & out_free;
   assign prod_ready = out_free;

   // round products and saturate the integral
   always_comb begin
      p_term     = pidsaw_pkg::round16(prod.p_prod);
      d_term     = pidsaw_pkg::round16(prod.d_prod);
      inc        = pidsaw_pkg::round16(prod.i_prod);
      integ_wide = 49'(integral_sum_ff) + 49'(inc);
      if (integ_wide > pidsaw_pkg::INTEG_MAX) begin
         integ = 32'sh7FFF_FFFF;
      end else if (integ_wide < pidsaw_pkg::INTEG_MIN) begin
         integ = 32'sh8000_0000;
      end else begin
         integ = integ_wide[31:0];
      end
   end

   // sum and clamp, high clamp tested first; clamped steps keep the old integral
   always_comb begin
      sum             = 50'(p_term) + 50'(d_term) + 50'(integ);
      integral_sum_in = integral_sum_ff;
      if (sum > 50'(cfg.drive_max)) begin
         drive_in = cfg.drive_max;
         limit_in = pidsaw_pkg::LIMIT_HIGH;
      end else if (sum < 50'(cfg.drive_min)) begin
         drive_in = cfg.drive_min;
         limit_in = pidsaw_pkg::LIMIT_LOW;
      end else begin
         drive_in        = sum[30:0];
         limit_in        = pidsaw_pkg::LIMIT_NONE;
         integral_sum_in = integ;
      end
   end

   // integral state
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_sum_ff <= '0;
      end else if (s2_go) begin
         integral_sum_ff <= integral_sum_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= prod_valid;
      end
      if (s2_go) begin
         drive_ff <= drive_in;
         limit_ff <= limit_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = drive_ff;
   assign rsp_limit_state = limit_ff;

   // checks
   `PIDSAW_ASSERT_NEXT(a_clamp_keeps_integral, s2_go && limit_in != pidsaw_pkg::LIMIT_NONE, integral_sum_ff == $past(integral_sum_ff))
   `PIDSAW_ASSERT_NEXT(a_integral_idle_stable, !s2_go, $stable(integral_sum_ff))
   `PIDSAW_ASSERT_NEXT(a_result_drains, rsp_valid_ff && rsp_ready && !prod_valid, !rsp_valid_ff)

endmodule

// ===== sv/pid_step_angle_wrap_antiwindup_top.sv =====
// PID step with angle wrap and anti-windup: one request in, one result out.
// Each request passes an input register, a product register (three 32x32
// multiplies for P, I and D) and a result register, and a new request is
// taken every cycle while results are taken; the sustained rate of one
// request per cycle is set by the back stage, which adds the integral,
// clamps and writes the integral back in the same cycle as its result.
// Register writes are expected only while no request is in flight.
module pid_step_angle_wrap_antiwindup_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [30:0] req_target_value,
   input  logic signed [30:0] req_measured_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [30:0] rsp_drive_value,
   output logic [1:0]         rsp_limit_state
);

   pidsaw_pkg::cfg_type      cfg;
   pidsaw_pkg::products_type prod;
   logic                     prod_valid;
   logic                     prod_ready;

   // configuration registers
   pidsaw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // error, difference and products
   pidsaw_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_target_value   (req_target_value),
      .req_measured_value (req_measured_value),
      .prod_valid         (prod_valid),
      .prod_ready         (prod_ready),
      .prod               (prod)
   );

   // integral, clamp and result
   pidsaw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .prod_valid      (prod_valid),
      .prod_ready      (prod_ready),
      .prod            (prod),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_value (rsp_drive_value),
      .rsp_limit_state (rsp_limit_state)
   );

endmodule

// ===== dv/pid_step_angle_wrap_antiwindup_top_tb.sv =====
// self-checking testbench for the pid step block with angle wrap and anti-windup
module pid_step_angle_wrap_antiwindup_top_tb;

   localparam int     IDLE_LIMIT      = 4000;
   localparam int     DRAIN_SLACK     = 4;
   localparam int     RANDOM_PHASES   = 8;
   localparam int     ITEMS_PER_PHASE = 115;
   localparam int     REG_PAST_END    = 6;
   localparam longint PI_FIX          = 205887;
   localparam longint TWO_PI_FIX      = 411775;
   localparam longint Q_MAX           = 64'sd1073741823;
   localparam longint Q_MIN           = -64'sd1073741824;
   localparam longint INT32_HI        = 64'sd2147483647;
   localparam longint INT32_LO        = -64'sd2147483648;

   typedef struct {
      logic signed [30:0] target;
      logic signed [30:0] measured;
   } setpoint_type;

   typedef struct {
      logic signed [30:0]    drive;
      pidsaw_pkg::limit_type limit;
   } drive_type;

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               csr_psel           = 1'b0;
   logic               csr_penable        = 1'b0;
   logic               csr_pwrite         = 1'b0;
   logic [4:0]         csr_paddr          = '0;
   logic [31:0]        csr_pwdata         = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;
   logic               req_valid          = 1'b0;
   logic               req_ready;
   logic signed [30:0] req_target_value   = '0;
   logic signed [30:0] req_measured_value = '0;
   logic               rsp_valid;
   logic               rsp_ready          = 1'b0;
   logic signed [30:0] rsp_drive_value;
   logic [1:0]         rsp_limit_state;

   // register shadow, starting at the reset values
   longint kp_gain_q     = 0;
   longint ki_times_dt_q = 0;
   longint kd_over_dt_q  = 0;
   longint drive_min_q   = Q_MIN;
   longint drive_max_q   = Q_MAX;
   logic   angle_mode_q  = 1'b0;

   // controller state shadow
   longint integ_acc    = 0;
   longint last_meas    = 0;
   logic   first_sample = 1'b1;

   setpoint_type setpoint_q[$];
   drive_type    drive_expect_q[$];

   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int mismatches      = 0;
   int requests_sent   = 0;
   int results_checked = 0;
   int high_clamps     = 0;
   int low_clamps      = 0;
   int settings_loaded = 0;
   int idle_cycles     = 0;

   pid_step_angle_wrap_antiwindup_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_target_value   (req_target_value),
      .req_measured_value (req_measured_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_value    (rsp_drive_value),
      .rsp_limit_state    (rsp_limit_state)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // wrap once by two pi when outside plus or minus pi
   function automatic longint wrap_pi(input longint v);
      if (v > PI_FIX) return v - TWO_PI_FIX;
      if (v < -PI_FIX) return v + TWO_PI_FIX;
      return v;
   endfunction

   // q.32 product to q.16, nearest with ties upward
   function automatic longint round_q16(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   // one controller step: drive and clamp status, updates the shadow state
   function automatic drive_type step_controller(input logic signed [30:0] target,
                                                 input logic signed [30:0] measured);
      longint err, diff, integ, p_term, d_term, total;
      drive_type r;
      err  = longint'(target) - longint'(measured);
      diff = 0;
      if (angle_mode_q) err = wrap_pi(err);
      integ = integ_acc + round_q16(err * ki_times_dt_q);
      if (integ > INT32_HI) integ = INT32_HI;
      else if (integ < INT32_LO) integ = INT32_LO;
      if (!first_sample) begin
         diff = longint'(measured) - last_meas;
         if (angle_mode_q) diff = wrap_pi(diff);
      end
      p_term = round_q16(err * kp_gain_q);
      d_term = round_q16(diff * kd_over_dt_q);
      total  = p_term + d_term + integ;
      // high clamp wins when the limits are inverted
      if (total > drive_max_q) begin
         r.drive = drive_max_q[30:0];
         r.limit = pidsaw_pkg::LIMIT_HIGH;
      end else if (total < drive_min_q) begin
         r.drive = drive_min_q[30:0];
         r.limit = pidsaw_pkg::LIMIT_LOW;
      end else begin
         r.drive   = total[30:0];
         r.limit   = pidsaw_pkg::LIMIT_NONE;
         integ_acc = integ;
      end
      last_meas    = longint'(measured);
      first_sample = 1'b0;
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic longint q16(input int whole);
      return longint'(whole) * 65536;
   endfunction

   function automatic void queue_request(input longint target, input longint measured);
      setpoint_type s;
      s.target   = 31'(target);
      s.measured = 31'(measured);
      setpoint_q.push_back(s);
   endfunction

   // gain: mostly within plus or minus four, sometimes zero or a rail
   function automatic logic [31:0] pick_gain();
      case ($urandom_range(9))
         0: return '0;
         1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2, 3, 4, 5: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
         default: return 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
      endcase
   endfunction

   // clamp: usually a moderate bound on its own side, sometimes anything
   function automatic logic [30:0] pick_clamp(input bit upper);
      int mag;
      mag = $urandom_range(1 << 14, 1 << 24);
      case ($urandom_range(7))
         0: return upper ? 31'h3FFF_FFFF : 31'h4000_0000;
         1: return 31'($urandom());
         default: return upper ? 31'(mag) : 31'(-mag);
      endcase
   endfunction

   // setpoint or measurement value: full range, small, angles near pi, rails
   function automatic longint pick_value();
      logic signed [30:0] v;
      v = 31'($urandom());
      case ($urandom_range(9))
         3, 4, 5: return longint'($urandom_range(0, 1 << 20)) - (1 << 19);
         6: return longint'($urandom_range(0, 1 << 13)) - (1 << 12);
         7: return ($urandom_range(1) ? PI_FIX : -PI_FIX)
                   + longint'($urandom_range(0, 4)) - 2;
         8: case ($urandom_range(3))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return 0;
               default: return 3 * PI_FIX + 1;
            endcase
         default: return longint'(v);
      endcase
   endfunction

   // apb write: setup cycle, access cycle, then release
   task automatic csr_write(input int unsigned index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         pidsaw_pkg::REG_KP_GAIN:     kp_gain_q     = longint'($signed(value));
         pidsaw_pkg::REG_KI_TIMES_DT: ki_times_dt_q = longint'($signed(value));
         pidsaw_pkg::REG_KD_OVER_DT:  kd_over_dt_q  = longint'($signed(value));
         pidsaw_pkg::REG_DRIVE_MIN:   drive_min_q   = longint'($signed(value[30:0]));
         pidsaw_pkg::REG_DRIVE_MAX:   drive_max_q   = longint'($signed(value[30:0]));
         pidsaw_pkg::REG_ANGLE_MODE:  angle_mode_q  = value[0];
         default: ;
      endcase
   endtask

   // full register set; unused upper bits carry noise
   task automatic load_settings(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] kd, input logic [30:0] dmin,
                                input logic [30:0] dmax, input logic mode);
      csr_write(pidsaw_pkg::REG_KP_GAIN, kp);
      csr_write(pidsaw_pkg::REG_KI_TIMES_DT, ki);
      csr_write(pidsaw_pkg::REG_KD_OVER_DT, kd);
      csr_write(pidsaw_pkg::REG_DRIVE_MIN, {1'($urandom_range(1)), dmin});
      csr_write(pidsaw_pkg::REG_DRIVE_MAX, {1'($urandom_range(1)), dmax});
      csr_write(pidsaw_pkg::REG_ANGLE_MODE, {31'($urandom()), mode});
      settings_loaded++;
   endtask

   // hold off until every request is through and every result is back
   task automatic wait_drained();
      do @(posedge clock);
      while (setpoint_q.size() != 0 || req_valid || drive_expect_q.size() != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // steer the integral back near zero so the next setting does not start on a rail
   task automatic bleed_integrator();
      longint err;
      load_settings('0, 32'h0001_0000, '0, 31'h4000_0000, 31'h3FFF_FFFF, 1'b0);
      err = -integ_acc;
      if (err > INT32_HI) err = INT32_HI;
      queue_request(err >>> 1, (err >>> 1) - err);
      wait_drained();
   endtask

   // request driver, predicting each accepted request
   always @(posedge clock) begin : driver_proc
      setpoint_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            drive_expect_q.push_back(step_controller(req_target_value, req_measured_value));
            requests_sent++;
         end
         if (!req_valid || req_ready) begin
            if (setpoint_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = setpoint_q.pop_front();
               req_valid          <= 1'b1;
               req_target_value   <= next_item.target;
               req_measured_value <= next_item.measured;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and compare
   always @(posedge clock) begin : monitor_proc
      drive_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (drive_expect_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected result: drive %0d limit %0d",
                                       rsp_drive_value, rsp_limit_state));
            end else begin
               want = drive_expect_q.pop_front();
               results_checked++;
               if (rsp_drive_value !== want.drive)
                  flag_mismatch($sformatf("result %0d drive: got %0d, want %0d",
                                          results_checked, rsp_drive_value, want.drive));
               if (rsp_limit_state !== want.limit)
                  flag_mismatch($sformatf("result %0d limit: got %0d, want %0d",
                                          results_checked, rsp_limit_state, want.limit));
               case (want.limit)
                  pidsaw_pkg::LIMIT_HIGH: high_clamps++;
                  pidsaw_pkg::LIMIT_LOW:  low_clamps++;
                  default: ;
               endcase
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      longint aim, track;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // angle mode: first step, rounding ties, wrap edges, beyond three pi, rails
      load_settings(32'h0000_8000, 32'h0000_4000, 32'h0001_8000,
                    31'(q16(-100)), 31'(q16(100)), 1'b1);
      queue_request(q16(3), 32768);
      queue_request(1, 0);
      queue_request(0, 1);
      queue_request(PI_FIX + 1000, 0);
      queue_request(0, PI_FIX);
      queue_request(PI_FIX, 0);
      queue_request(0, PI_FIX + 113);
      queue_request(700000, 0);
      queue_request(0, -700000);
      queue_request(Q_MAX, Q_MIN);
      queue_request(Q_MIN, Q_MAX);
      queue_request(0, 0);
      wait_drained();

      // integral saturation both ways, held in range by a negative p term
      load_settings(32'hFFFF_0000, 32'h7FFF_FFFF, '0, 31'h4000_0000, 31'h3FFF_FFFF, 1'b0);
      csr_write(REG_PAST_END, $urandom());
      queue_request(Q_MAX, Q_MIN);
      queue_request(Q_MAX, Q_MIN);
      queue_request(Q_MIN, Q_MAX);
      queue_request(Q_MIN, Q_MAX);
      queue_request(0, 0);
      wait_drained();
      bleed_integrator();

      // lower clamp above the upper one
      load_settings(32'h0001_0000, '0, '0, 31'(q16(10)), 31'(q16(-10)), 1'b0);
      queue_request(0, 0);
      queue_request(q16(-20), 0);
      queue_request(q16(5), 0);
      wait_drained();

      // random settings, mostly tracking runs with some independent noise
      track = 0;
      aim   = 0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         bleed_integrator();
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin send_idle_pct = 6; rsp_stall_pct = 6; end
         endcase
         if (phase == 1)
            load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          31'h4000_0000, 31'h3FFF_FFFF, 1'b1);
         else if (phase == 5)
            load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          31'h3FFF_FFFF, 31'h4000_0000, 1'b0);
         else
            load_settings(pick_gain(), pick_gain(), pick_gain(),
                          pick_clamp(1'b0), pick_clamp(1'b1), 1'(phase % 2 == 0));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(9) < 7) begin
               if ($urandom_range(15) == 0) aim = pick_value();
               track = track + (aim - track) / 4
                       + longint'($urandom_range(0, 8192)) - 4096;
               if (track > Q_MAX) track = Q_MAX;
               if (track < Q_MIN) track = Q_MIN;
               queue_request(aim, track);
            end else begin
               queue_request(pick_value(), pick_value());
            end
         end
         wait_drained();
      end

      repeat (DRAIN_SLACK) @(posedge clock);
      if (drive_expect_q.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", drive_expect_q.size()));
      $display("Covered %0d requests over %0d register settings and four idle patterns:",
               requests_sent, settings_loaded);
      $display("%0d results checked, %0d clamped high, %0d clamped low, %0d mismatches",
               results_checked, high_clamps, low_clamps, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
